// ----- rtl/cipd_pkg.sv -----
// Shared types, constants and helpers for the case-insensitive pattern detector.
// No dependencies.
package cipd_pkg;

  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int MASK_W        = 4;
  localparam int LEN_NIB_W     = 4;

  typedef logic [7:0]          byte_t;
  typedef logic [MASK_W-1:0]   mask_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_PATTERN_A   = 3'd0;
  localparam cfg_idx_t CFG_PATTERN_B   = 3'd1;
  localparam cfg_idx_t CFG_PATTERN_C   = 3'd2;
  localparam cfg_idx_t CFG_PATTERN_D   = 3'd3;
  localparam cfg_idx_t CFG_LENGTHS     = 3'd4;

  localparam cfg_idx_t PATTERN_IDX [MASK_W] = '{
    CFG_PATTERN_A, CFG_PATTERN_B, CFG_PATTERN_C, CFG_PATTERN_D
  };

  localparam byte_t PIPE_CHAR = 8'h7C;
  localparam byte_t UPPER_LO  = 8'h41;
  localparam byte_t UPPER_HI  = 8'h5A;
  localparam byte_t CASE_OFS  = 8'h20;

  function automatic byte_t fold_lower(input byte_t c);
    if (c >= UPPER_LO && c <= UPPER_HI) begin
      return c + CASE_OFS;
    end
    return c;
  endfunction

endpackage

// ----- rtl/cipd_if.sv -----
// Valid/ready channel interfaces for the command byte stream and the match result.
// Depends on cipd_pkg.
interface cipd_in_if;
  logic                 valid;
  logic                 ready;
  cipd_pkg::byte_t      cmd_byte;
  logic                 last_byte;

  modport source (output valid, cmd_byte, last_byte, input ready);
  modport sink   (input valid, cmd_byte, last_byte, output ready);
endinterface

interface cipd_out_if;
  logic                 valid;
  logic                 ready;
  cipd_pkg::mask_t      found_mask;
  logic                 is_safe;
  logic                 has_pipe;

  modport source (output valid, found_mask, is_safe, has_pipe, input ready);
  modport sink   (input valid, found_mask, is_safe, has_pipe, output ready);
endinterface

// ----- rtl/case_insensitive_pattern_detector_top.sv -----
// Case-insensitive multi-pattern detector: top level with config registers and stream state.
// Depends on cipd_pkg, cipd_if and cipd_slot_match.
// A last byte is held in the input stage register, then its result in the result register.
// Throughput: 1 byte per cycle; a last byte waits only while the previous result is unaccepted.
// Reset: synchronous active-low rst_n clears patterns, lengths, stream state and both stages.
module case_insensitive_pattern_detector_top #(
  parameter int NUM_SLOTS       = 4,
  parameter int MAX_PATTERN_LEN = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  cipd_pkg::cfg_idx_t         cfg_index,
  input  logic [cipd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  cipd_in_if.sink                    in_ch,
  cipd_out_if.source                 out_ch
);

  localparam int LEN_W = $clog2(MAX_PATTERN_LEN + 1);
  localparam int WIN_D = (MAX_PATTERN_LEN > 1) ? MAX_PATTERN_LEN - 1 : 1;
  localparam int PAT_W = MAX_PATTERN_LEN * 8;

  // configuration, stored lowered and clamped
  logic [PAT_W-1:0]        pattern_r [NUM_SLOTS];
  logic [LEN_W-1:0]        len_r     [NUM_SLOTS];

  // input stage
  logic                    cur_valid_r;
  cipd_pkg::byte_t         cur_byte_r;
  logic                    cur_last_r;

  // stream state
  cipd_pkg::byte_t         recent_r  [WIN_D];
  logic [LEN_W-1:0]        seen_r;
  cipd_pkg::mask_t         match_r;
  logic                    pipe_r;

  // result stage
  logic                    out_valid_r;
  cipd_pkg::mask_t         out_found_r;
  logic                    out_safe_r;
  logic                    out_pipe_r;

  logic                    cur_go;
  logic [LEN_W-1:0]        seen_nxt;
  cipd_pkg::mask_t         match_nxt;
  logic                    pipe_nxt;
  logic [PAT_W-1:0]        window;
  logic [NUM_SLOTS-1:0]    slot_hit;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        pattern_r[s] <= '0;
        len_r[s]     <= '0;
      end
    end else if (cfg_we) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (cfg_index == cipd_pkg::PATTERN_IDX[s]) begin
          for (int b = 0; b < MAX_PATTERN_LEN; b++) begin
            pattern_r[s][8*b +: 8] <= cipd_pkg::fold_lower(cfg_wdata[8*b +: 8]);
          end
        end
        if (cfg_index == cipd_pkg::CFG_LENGTHS) begin
          if (cfg_wdata[cipd_pkg::LEN_NIB_W*s +: cipd_pkg::LEN_NIB_W] >
              cipd_pkg::LEN_NIB_W'(MAX_PATTERN_LEN)) begin
            len_r[s] <= LEN_W'(MAX_PATTERN_LEN);
          end else begin
            len_r[s] <= LEN_W'(cfg_wdata[cipd_pkg::LEN_NIB_W*s +: cipd_pkg::LEN_NIB_W]);
          end
        end
      end
    end
  end

  // ---------------- handshake ----------------
  assign cur_go      = cur_valid_r && (!cur_last_r || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !cur_valid_r || cur_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      cur_valid_r <= 1'b1;
    end else if (cur_go) begin
      cur_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cur_byte_r <= cipd_pkg::fold_lower(in_ch.cmd_byte);
      cur_last_r <= in_ch.last_byte;
    end
  end

  // ---------------- compare ----------------
  always_comb begin
    window[7:0] = cur_byte_r;
    for (int k = 1; k < MAX_PATTERN_LEN; k++) begin
      window[8*k +: 8] = recent_r[k-1];
    end
  end

  assign seen_nxt = (seen_r == LEN_W'(MAX_PATTERN_LEN)) ? seen_r : seen_r + 1'b1;
  assign pipe_nxt = pipe_r || (cur_byte_r == cipd_pkg::PIPE_CHAR);

  for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_slot
    cipd_slot_match #(
      .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
    ) u_slot (
      .pattern (pattern_r[s]),
      .window  (window),
      .len     (len_r[s]),
      .seen    (seen_nxt),
      .hit     (slot_hit[s])
    );
  end

  assign match_nxt = match_r | cipd_pkg::MASK_W'(slot_hit);

  // ---------------- stream state ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      match_r <= '0;
      pipe_r  <= 1'b0;
      for (int k = 0; k < WIN_D; k++) begin
        recent_r[k] <= '0;
      end
    end else if (cur_go) begin
      if (cur_last_r) begin
        seen_r  <= '0;
        match_r <= '0;
        pipe_r  <= 1'b0;
        for (int k = 0; k < WIN_D; k++) begin
          recent_r[k] <= '0;
        end
      end else begin
        seen_r  <= seen_nxt;
        match_r <= match_nxt;
        pipe_r  <= pipe_nxt;
        if (MAX_PATTERN_LEN > 1) begin
          recent_r[0] <= cur_byte_r;
          for (int k = 1; k < WIN_D; k++) begin
            recent_r[k] <= recent_r[k-1];
          end
        end
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cur_go && cur_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cur_go && cur_last_r) begin
      out_found_r <= match_nxt;
      out_safe_r  <= (match_nxt == '0);
      out_pipe_r  <= pipe_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.found_mask = out_found_r;
  assign out_ch.is_safe    = out_safe_r;
  assign out_ch.has_pipe   = out_pipe_r;

  // ---------------- assertions ----------------
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cur_go && cur_last_r))
    else $error("result without a last-byte transaction");

  a_safe_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_safe_r == (out_found_r == '0)))
    else $error("is_safe disagrees with found_mask");

  a_unused_slots_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_found_r >> NUM_SLOTS) == '0))
    else $error("found_mask bit set beyond configured slots");

  a_seen_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= LEN_W'(MAX_PATTERN_LEN))
    else $error("byte count above saturation");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_go && cur_last_r) |=> (seen_r == '0 && match_r == '0 && !pipe_r))
    else $error("stream state not cleared after last byte");

endmodule

// ----- rtl/cipd_slot_match.sv -----
// One pattern slot compared against the lowered byte window (current byte at offset 0).
// Depends on cipd_pkg.
module cipd_slot_match #(
  parameter int MAX_PATTERN_LEN = 8,
  localparam int LEN_W = $clog2(MAX_PATTERN_LEN + 1)
) (
  input  logic [MAX_PATTERN_LEN*8-1:0] pattern,
  input  logic [MAX_PATTERN_LEN*8-1:0] window,
  input  logic [LEN_W-1:0]             len,
  input  logic [LEN_W-1:0]             seen,
  output logic                         hit
);

  logic [MAX_PATTERN_LEN-1:0] byte_ok;

  // pattern byte j lines up with window offset len-1-j
  always_comb begin
    cipd_pkg::byte_t wb;
    wb = '0;
    for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
      wb = '0;
      for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
        if (k + j + 1 == int'(len)) begin
          wb = window[8*k +: 8];
        end
      end
      byte_ok[j] = (j >= int'(len)) || (pattern[8*j +: 8] == wb);
    end
  end

  assign hit = (len != '0) && (seen >= len) && (&byte_ok);

endmodule
